[rtl/assert_macros.svh]
// Assertion macros shared by the encoder RTL.
// Depends on the signals clk_i and rst_ni in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define RS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("encoder assertion failed");

// Check that a condition in one cycle implies a condition in the next one.
`define RS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("encoder assertion failed");

`endif

[rtl/rsenc_pkg.sv]
// Types, constants and GF(64) helper functions of the Reed-Solomon parity encoder.
// Used by rsenc_byte_update and the top level; depends on nothing else.
package rsenc_pkg;

  // Field polynomial x^6+x+1, its top bit, and the symbol mask.
  localparam logic [6:0] GfPoly  = 7'h43;
  localparam logic [6:0] GfTop   = 7'h40;
  localparam logic [6:0] SymMask = 7'h3f;

  // Number of parity bytes that close a message.
  localparam logic [1:0] ParBytes = 2'd3;

  typedef logic [5:0] sym_t;
  typedef logic [3:0][5:0] par_t;

  // Position of the next byte inside its three-byte group.
  typedef enum logic [1:0] {
    PhA = 2'd0,
    PhB = 2'd1,
    PhC = 2'd2
  } phase_e;

  // Running encoder state carried from byte to byte.
  typedef struct packed {
    par_t   par;
    phase_e phase;
    logic [3:0] carry;
  } enc_state_t;

  // Multiply a field element by alpha.
  function automatic sym_t gf_times_x(sym_t v);
    logic [6:0] t;
    t = {v, 1'b0};
    if ((t & GfTop) != 7'h00) begin
      t = t ^ GfPoly;
    end
    return sym_t'(t & SymMask);
  endfunction

  // One shift of the four-stage parity register with one input symbol.
  function automatic par_t lfsr_symbol(par_t p, sym_t s);
    sym_t f;
    sym_t p1;
    sym_t p2;
    sym_t p3;
    sym_t p4;
    par_t r;
    p1 = p[1];
    p2 = p[2];
    p3 = p[3];
    p4 = '0;
    f  = s ^ p[0];
    p2 = p2 ^ f;
    p3 = p3 ^ f;
    f  = gf_times_x(f);
    p1 = p1 ^ f;
    f  = gf_times_x(f);
    p1 = p1 ^ f;
    p2 = p2 ^ f;
    f  = gf_times_x(f);
    p1 = p1 ^ f;
    p2 = p2 ^ f;
    f  = gf_times_x(f);
    p1 = p1 ^ f;
    p2 = p2 ^ f;
    p3 = p3 ^ f;
    p4 = p4 ^ f;
    f  = gf_times_x(f);
    p4 = p4 ^ f;
    r[0] = p1;
    r[1] = p2;
    r[2] = p3;
    r[3] = p4;
    return r;
  endfunction

  // Unpack one byte at the current phase into symbols and advance the phase.
  function automatic enc_state_t take_byte(enc_state_t st, logic [7:0] b);
    enc_state_t r;
    r = st;
    case (st.phase)
      PhB: begin
        r.par   = lfsr_symbol(st.par, {b[3:0], st.carry[1:0]});
        r.carry = b[7:4];
        r.phase = PhC;
      end
      PhC: begin
        r.par   = lfsr_symbol(lfsr_symbol(st.par, {b[1:0], st.carry}), b[7:2]);
        r.carry = 4'h0;
        r.phase = PhA;
      end
      default: begin
        r.par   = lfsr_symbol(st.par, b[5:0]);
        r.carry = {2'b00, b[7:6]};
        r.phase = PhB;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/rsenc_byte_update.sv]
// Combinational next-state logic for one message byte, with group padding on the last byte.
// Depends on rsenc_pkg.
module rsenc_byte_update (
  input  rsenc_pkg::enc_state_t state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_i,
  output rsenc_pkg::enc_state_t state_o,
  output logic [23:0]           parity_o
);

  rsenc_pkg::enc_state_t st_byte;
  rsenc_pkg::enc_state_t st_pad1;
  rsenc_pkg::enc_state_t st_pad2;

  // Feed the byte, then complete an open group with zero bytes.
  always_comb begin
    st_byte = rsenc_pkg::take_byte(state_i, data_byte_i);
    st_pad1 = st_byte;
    if (st_byte.phase != rsenc_pkg::PhA) begin
      st_pad1 = rsenc_pkg::take_byte(st_byte, 8'h00);
    end
    st_pad2 = st_pad1;
    if (st_pad1.phase != rsenc_pkg::PhA) begin
      st_pad2 = rsenc_pkg::take_byte(st_pad1, 8'h00);
    end
  end

  // Pack the four parity symbols into three bytes, lowest byte sent first.
  assign parity_o = {st_pad2.par[3], st_pad2.par[2], st_pad2.par[1], st_pad2.par[0]};

  // The state clears once a message is closed.
  assign state_o = last_i ? rsenc_pkg::enc_state_t'('0) : st_byte;

endmodule

[rtl/reed_solomon_gf64_parity_encoder_unit.sv]
// A message byte waits in the skid register if it cannot be taken, then goes to the
// output register. Throughput: one message byte per cycle while the output accepts;
// the last byte is followed by three parity bytes, during which no byte is encoded.
// The input stage is a skid register, so tready on the input side is a register.
// Reset is asynchronous and active low; it clears the encoder state and all valid flags.
`include "assert_macros.svh"

module reed_solomon_gf64_parity_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last
  // Output stream.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] is_parity
  output logic       m_axis_tlast_o    // end_of_frame
);

  // Skid register on the input side.
  logic       skid_valid_q, skid_valid_d;
  logic [7:0] skid_data_q;
  logic       skid_last_q;

  // Encoder state.
  rsenc_pkg::enc_state_t state_q, state_d;
  rsenc_pkg::enc_state_t state_next;
  logic [23:0]           parity_next;

  // Output register and pending parity bytes.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_par_q, out_par_d;
  logic        out_eof_q, out_eof_d;
  logic [1:0]  pcnt_q, pcnt_d;
  logic [23:0] pbuf_q, pbuf_d;

  logic       head_valid;
  logic [7:0] head_data;
  logic       head_last;
  logic       out_free;
  logic       take_head;

  // The item at the head is the skid entry if one is held, else the port.
  assign s_axis_tready_o = !skid_valid_q;
  assign head_valid      = skid_valid_q || s_axis_tvalid_i;
  assign head_data       = skid_valid_q ? skid_data_q : s_axis_tdata_i;
  assign head_last       = skid_valid_q ? skid_last_q : s_axis_tlast_i;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign take_head = out_free && (pcnt_q == 2'd0) && head_valid;

  rsenc_byte_update u_byte_update (
    .state_i     (state_q),
    .data_byte_i (head_data),
    .last_i      (head_last),
    .state_o     (state_next),
    .parity_o    (parity_next)
  );

  // Skid register fills when a transfer arrives that the output cannot take.
  always_comb begin
    if (skid_valid_q) begin
      skid_valid_d = !take_head;
    end else begin
      skid_valid_d = s_axis_tvalid_i && !take_head;
    end
  end

  // Output register: pending parity first, then the next message byte.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_par_d   = out_par_q;
    out_eof_d   = out_eof_q;
    pcnt_d      = pcnt_q;
    pbuf_d      = pbuf_q;
    state_d     = state_q;
    if (out_free) begin
      if (pcnt_q != 2'd0) begin
        out_valid_d = 1'b1;
        out_data_d  = pbuf_q[7:0];
        out_par_d   = 1'b1;
        out_eof_d   = (pcnt_q == 2'd1);
        pbuf_d      = {8'h00, pbuf_q[23:8]};
        pcnt_d      = pcnt_q - 2'd1;
      end else if (head_valid) begin
        out_valid_d = 1'b1;
        out_data_d  = head_data;
        out_par_d   = 1'b0;
        out_eof_d   = 1'b0;
        state_d     = state_next;
        if (head_last) begin
          pbuf_d = parity_next;
          pcnt_d = rsenc_pkg::ParBytes;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      pcnt_q       <= 2'd0;
      state_q      <= '0;
    end else begin
      skid_valid_q <= skid_valid_d;
      out_valid_q  <= out_valid_d;
      pcnt_q       <= pcnt_d;
      state_q      <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      skid_data_q <= s_axis_tdata_i;
      skid_last_q <= s_axis_tlast_i;
    end
    out_data_q <= out_data_d;
    out_par_q  <= out_par_d;
    out_eof_q  <= out_eof_d;
    pbuf_q     <= pbuf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_par_q;
  assign m_axis_tlast_o  = out_eof_q;

  // A closing byte arms exactly three parity bytes and clears the state.
  `RS_ASSERT_NEXT(a_last_arms_parity, take_head && head_last, pcnt_q == rsenc_pkg::ParBytes)
  `RS_ASSERT_NEXT(a_last_clears_state, take_head && head_last, state_q == '0)
  // Parity is pending only behind a byte shown at the output.
  `RS_ASSERT(a_pending_behind_output, (pcnt_q == 2'd0) || out_valid_q)
  // A parity byte that does not end the frame has more parity behind it.
  `RS_ASSERT(a_parity_run_complete,
             !(out_valid_q && out_par_q && !out_eof_q) || (pcnt_q != 2'd0))

endmodule

[bench/reed_solomon_gf64_parity_encoder_unit_test.sv]
// Self-checking bench for the GF(64) Reed-Solomon parity encoder stream unit.
// It drives byte messages on the input stream and checks the pass-through and parity
// bytes against its own parity predictor or a directed table; it depends only on the RTL and rsenc_pkg.
`timescale 1ns / 100ps

module reed_solomon_gf64_parity_encoder_unit_test;

  // Generator taps of the four parity stages, and x^6 reduced by x^6+x+1.
  localparam logic [5:0] Tap0     = 6'h1e;
  localparam logic [5:0] Tap1     = 6'h1d;
  localparam logic [5:0] Tap2     = 6'h11;
  localparam logic [5:0] Tap3     = 6'h30;
  localparam logic [5:0] XSixRed  = 6'h03;
  localparam int         MsgItems = 80;
  localparam int         MaxShown = 10;

  // One output byte as the receiver should see it.
  typedef struct packed {
    logic [7:0] val;
    logic       is_par;
    logic       eof;
  } cw_byte_t;

  // One directed transfer; par holds the three typed parity bytes, lowest first.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [23:0] par;
  } stim_row_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_valid  = 1'b0;
  logic [7:0] s_data   = 8'h00;
  logic       s_last   = 1'b0;
  logic       m_ready  = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_mismatch     = 0;
  int n_in           = 0;
  int n_out          = 0;
  int n_msg          = 0;

  // Predictor state: parity stages, position in the byte group, held high bits.
  logic [5:0]         chk [4];
  rsenc_pkg::phase_e  grp_pos;
  logic [3:0]         held_bits;

  cw_byte_t due_bytes[$];

  reed_solomon_gf64_parity_encoder_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock and a single reset pulse at the start.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Full GF(64) product by shift and add.
  function automatic logic [5:0] gf64_mul(input logic [5:0] a, input logic [5:0] b);
    logic [5:0] acc;
    logic [5:0] sh;
    int i;
    acc = '0;
    sh  = a;
    for (i = 0; i < 6; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[4:0], 1'b0} ^ (sh[5] ? XSixRed : 6'h00);
    end
    return acc;
  endfunction

  // Divide one more symbol into the parity register.
  function automatic void absorb_symbol(input logic [5:0] s);
    logic [5:0] fb;
    fb     = s ^ chk[0];
    chk[0] = chk[1] ^ gf64_mul(fb, Tap0);
    chk[1] = chk[2] ^ gf64_mul(fb, Tap1);
    chk[2] = chk[3] ^ gf64_mul(fb, Tap2);
    chk[3] = gf64_mul(fb, Tap3);
  endfunction

  // Three bytes carry four symbols, taken from the lowest bits up.
  function automatic void absorb_byte(input logic [7:0] b);
    case (grp_pos)
      rsenc_pkg::PhB: begin
        absorb_symbol({b[3:0], held_bits[1:0]});
        held_bits = b[7:4];
        grp_pos   = rsenc_pkg::PhC;
      end
      rsenc_pkg::PhC: begin
        absorb_symbol({b[1:0], held_bits});
        absorb_symbol(b[7:2]);
        held_bits = 4'h0;
        grp_pos   = rsenc_pkg::PhA;
      end
      default: begin
        absorb_symbol(b[5:0]);
        held_bits = {2'b00, b[7:6]};
        grp_pos   = rsenc_pkg::PhB;
      end
    endcase
  endfunction

  function automatic void clear_encoder();
    int i;
    for (i = 0; i < 4; i++) begin
      chk[i] = '0;
    end
    grp_pos   = rsenc_pkg::PhA;
    held_bits = 4'h0;
  endfunction

  // Expected output bytes for one accepted input byte; returns their count.
  function automatic int encode_transfer(input logic [7:0] d, input logic l,
                                         output cw_byte_t res[4]);
    logic [23:0] packed_par;
    int k;
    res[0] = {d, 1'b0, 1'b0};
    absorb_byte(d);
    if (!l) begin
      return 1;
    end
    // Zero-pad the open group, then emit the four symbols as three bytes.
    while (grp_pos != rsenc_pkg::PhA) begin
      absorb_byte(8'h00);
    end
    packed_par = {chk[3], chk[2], chk[1], chk[0]};
    for (k = 1; k < 4; k++) begin
      res[k] = {packed_par[8*(k-1) +: 8], 1'b1, (k == 3)};
    end
    clear_encoder();
    return 4;
  endfunction

  task automatic flag_error(input string msg);
    n_mismatch++;
    if (n_mismatch <= MaxShown) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Offer one byte, wait for its transfer, then queue what it should produce.
  task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                           input logic [23:0] typed_par);
    cw_byte_t res[4];
    int n;
    int k;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    s_last  <= l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n = encode_transfer(d, l, res);
    // Rows with typed results replace the prediction.
    if (typed) begin
      res[0] = {d, 1'b0, 1'b0};
      if (l) begin
        for (k = 1; k < 4; k++) begin
          res[k] = {typed_par[8*(k-1) +: 8], 1'b1, (k == 3)};
        end
      end
    end
    for (k = 0; k < n; k++) begin
      due_bytes.push_back(res[k]);
    end
    n_in++;
    if (l) begin
      n_msg++;
    end
  endtask

  // Receiver: random stalls, and each output transfer checked in order.
  initial begin : out_check
    cw_byte_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_ready) begin
        n_out++;
        if (due_bytes.size() == 0) begin
          flag_error($sformatf("unexpected output byte %02h parity %0b end %0b",
                               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o));
        end else begin
          want = due_bytes.pop_front();
          if (m_axis_tdata_o !== want.val || m_axis_tuser_o !== want.is_par ||
              m_axis_tlast_o !== want.eof) begin
            flag_error($sformatf({"mismatch: expected byte %02h parity %0b end %0b,",
                                  " got byte %02h parity %0b end %0b"},
                                 want.val, want.is_par, want.eof,
                                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o));
          end
        end
      end
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed table, then random messages under four idling patterns.
  initial begin : stimulus
    stim_row_t dir_rows [24];
    int idle_tab  [4];
    int stall_tab [4];
    int ph;
    int cnt;
    int len;
    int j;
    int style;
    logic [7:0] d;

    // Zero messages and plain pass-through bytes have typed results.
    dir_rows = '{
      {8'h00, 1'b1, 1'b1, 24'h000000},  // one zero byte: parity all zero
      {8'hff, 1'b0, 1'b1, 24'h000000},
      {8'hff, 1'b0, 1'b1, 24'h000000},
      {8'hff, 1'b1, 1'b0, 24'h000000},  // last byte closes a full group
      {8'h80, 1'b0, 1'b1, 24'h000000},
      {8'h01, 1'b1, 1'b0, 24'h000000},  // last byte in the middle of a group
      {8'h3f, 1'b1, 1'b0, 24'h000000},  // single nonzero byte
      {8'hc0, 1'b0, 1'b1, 24'h000000},
      {8'h0f, 1'b0, 1'b1, 24'h000000},
      {8'hf0, 1'b0, 1'b1, 24'h000000},
      {8'h00, 1'b0, 1'b1, 24'h000000},
      {8'h01, 1'b1, 1'b0, 24'h000000},
      {8'h00, 1'b0, 1'b1, 24'h000000},
      {8'h00, 1'b0, 1'b1, 24'h000000},
      {8'h00, 1'b1, 1'b1, 24'h000000},  // all-zero group: parity all zero
      {8'h01, 1'b0, 1'b1, 24'h000000},
      {8'h02, 1'b0, 1'b1, 24'h000000},
      {8'h04, 1'b0, 1'b1, 24'h000000},
      {8'h08, 1'b0, 1'b1, 24'h000000},
      {8'h10, 1'b0, 1'b1, 24'h000000},
      {8'h20, 1'b0, 1'b1, 24'h000000},
      {8'h40, 1'b1, 1'b0, 24'h000000},
      {8'haa, 1'b0, 1'b1, 24'h000000},
      {8'h55, 1'b1, 1'b0, 24'h000000}
    };
    idle_tab  = '{0, 73, 0, 16};
    stall_tab = '{0, 0, 73, 16};
    clear_encoder();
    @(posedge clk_i iff rst_ni);

    for (j = 0; j < 24; j++) begin
      send_byte(dir_rows[j].data, dir_rows[j].last, dir_rows[j].typed, dir_rows[j].par);
    end

    // Random messages, mostly short, now and then a long one.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      cnt = 0;
      while (cnt < MsgItems) begin
        len   = ($urandom_range(9) == 0) ? $urandom_range(64, 24) : $urandom_range(8, 1);
        style = $urandom_range(9);
        for (j = 0; j < len; j++) begin
          d = (style == 0) ? 8'h00 : (style == 1) ? 8'hff : 8'($urandom_range(255));
          send_byte(d, (j == len - 1), 1'b0, 24'h000000);
        end
        cnt += len;
      end
    end
    s_valid <= 1'b0;

    // Drain, then leave room for any stray output.
    while (due_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    $display("encoded %0d messages from %0d input bytes; %0d output bytes checked",
             n_msg, n_in, n_out);
    $display("idling covered: none, sender only, receiver only, and both sides");
    if (n_mismatch == 0 && due_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rsenc_pkg.sv
rtl/rsenc_byte_update.sv
rtl/reed_solomon_gf64_parity_encoder_unit.sv
bench/reed_solomon_gf64_parity_encoder_unit_test.sv
